// File: sv/sld_pkg.sv
// sld_pkg: shared widths, constants and types of the sphere light direction core
// no dependencies
`default_nettype none

package sld_pkg;

   localparam int PIX_W         = 8;
   localparam int COL_W         = 12;
   localparam int ROW_W         = 12;
   localparam int RADIUS_W      = 16;
   localparam int WIDTH_W       = 13;
   localparam int DIR_W         = 24;
   localparam int DIR_Z_W       = 23;
   localparam int CSR_INDEX_W   = 2;
   localparam int CSR_DATA_W    = 16;

   localparam int MAX_WIDTH_DEFAULT  = 4096;
   localparam int MAX_HEIGHT_DEFAULT = 4096;
   localparam int JOB_QUEUE_DEPTH    = 2;

   localparam logic [COL_W-1:0]    CENTER_COL_RESET  = '0;
   localparam logic [ROW_W-1:0]    CENTER_ROW_RESET  = '0;
   localparam logic [RADIUS_W-1:0] RADIUS_RESET      = 16'd16;
   localparam logic [WIDTH_W-1:0]  IMAGE_WIDTH_RESET = 13'd640;

   // 1.0 in q1.15
   localparam logic [31:0] Q15_ONE = 32'd32768;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CENTER_COL  = 2'd0,
      CSR_CENTER_ROW  = 2'd1,
      CSR_RADIUS      = 2'd2,
      CSR_IMAGE_WIDTH = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [COL_W-1:0] col;
      logic [ROW_W-1:0] row;
      logic [PIX_W-1:0] level;
   } job_type;

   typedef struct packed {
      logic [COL_W-1:0]    center_col;
      logic [ROW_W-1:0]    center_row;
      logic [RADIUS_W-1:0] radius_q4;
   } geom_type;

endpackage

`default_nettype wire

// File: sv/sld_req_if.sv
// sld_req_if: pixel request channel, valid/ready with pixel payload
// depends on sld_pkg
`default_nettype none

interface sld_req_if import sld_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] gray_level;
   logic             last_pixel;

   modport source (output valid, output gray_level, output last_pixel, input ready);
   modport sink   (input valid, input gray_level, input last_pixel, output ready);
endinterface

`default_nettype wire

// File: sv/sld_rsp_if.sv
// sld_rsp_if: light direction result channel, valid/ready with result payload
// depends on sld_pkg
`default_nettype none

interface sld_rsp_if import sld_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [DIR_W-1:0]  dir_x;
   logic signed [DIR_W-1:0]  dir_y;
   logic [DIR_Z_W-1:0]       dir_z;
   logic [COL_W-1:0]         best_col;
   logic [ROW_W-1:0]         best_row;
   logic [PIX_W-1:0]         peak_level;
   logic                     outside_sphere;

   modport source (output valid, output dir_x, output dir_y, output dir_z, output best_col,
                   output best_row, output peak_level, output outside_sphere, input ready);
   modport sink   (input valid, input dir_x, input dir_y, input dir_z, input best_col,
                   input best_row, input peak_level, input outside_sphere, output ready);
endinterface

`default_nettype wire

// File: sv/sld_front.sv
// sld_front: raster position counters and brightest pixel tracking
// depends on sld_pkg and sld_req_if; pushes one job per frame into the job queue
`default_nettype none

module sld_front import sld_pkg::*; #(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEFAULT,
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   sld_req_if.sink            req_if,
   input  logic [WIDTH_W-1:0] image_width,
   input  logic               queue_full,
   output logic               push,
   output job_type            push_job
);

   localparam logic [WIDTH_W-1:0] WIDTH_LIMIT = WIDTH_W'(MAX_WIDTH);
   localparam logic [ROW_W:0]     ROW_LIMIT   = (ROW_W+1)'(MAX_HEIGHT);

   logic [COL_W-1:0] cur_col_ff;
   logic [ROW_W-1:0] cur_row_ff;
   logic [COL_W-1:0] peak_col_ff;
   logic [ROW_W-1:0] peak_row_ff;
   logic [PIX_W-1:0] peak_store_ff;
   logic             have_peak_ff;

   logic [WIDTH_W-1:0] width_eff;
   logic [WIDTH_W-1:0] col_inc;
   logic [ROW_W:0]     row_inc;
   logic               take;
   logic               upd;

   assign req_if.ready = !queue_full;
   assign take         = req_if.valid && req_if.ready;
   assign upd          = !have_peak_ff || (req_if.gray_level > peak_store_ff);
   assign col_inc      = {1'b0, cur_col_ff} + WIDTH_W'(1);
   assign row_inc      = {1'b0, cur_row_ff} + (ROW_W+1)'(1);

   always_comb begin
      if (image_width == '0) begin
         width_eff = WIDTH_W'(1);
      end else if (image_width > WIDTH_LIMIT) begin
         width_eff = WIDTH_LIMIT;
      end else begin
         width_eff = image_width;
      end
   end

   assign push           = take && req_if.last_pixel;
   assign push_job.col   = upd ? cur_col_ff : peak_col_ff;
   assign push_job.row   = upd ? cur_row_ff : peak_row_ff;
   assign push_job.level = upd ? req_if.gray_level : peak_store_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_col_ff    <= '0;
         cur_row_ff    <= '0;
         peak_col_ff   <= '0;
         peak_row_ff   <= '0;
         peak_store_ff <= '0;
         have_peak_ff  <= 1'b0;
      end else if (take) begin
         if (req_if.last_pixel) begin
            cur_col_ff    <= '0;
            cur_row_ff    <= '0;
            peak_col_ff   <= '0;
            peak_row_ff   <= '0;
            peak_store_ff <= '0;
            have_peak_ff  <= 1'b0;
         end else begin
            if (upd) begin
               peak_col_ff   <= cur_col_ff;
               peak_row_ff   <= cur_row_ff;
               peak_store_ff <= req_if.gray_level;
               have_peak_ff  <= 1'b1;
            end
            if (col_inc >= width_eff) begin
               cur_col_ff <= '0;
               if (row_inc < ROW_LIMIT) begin
                  cur_row_ff <= row_inc[ROW_W-1:0];
               end
            end else begin
               cur_col_ff <= col_inc[COL_W-1:0];
            end
         end
      end
   end

endmodule

`default_nettype wire

// File: sv/sld_queue.sv
// sld_queue: short job queue between the pixel front and the math back
// depends on sld_pkg
`default_nettype none

module sld_queue import sld_pkg::*; #(
   parameter int DEPTH = JOB_QUEUE_DEPTH
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   input  logic    pop,
   output logic    full,
   output logic    empty,
   output job_type head_job
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   job_type          mem [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;

   assign full     = (count_ff == FULL_CNT);
   assign empty    = (count_ff == '0);
   assign head_job = mem[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !full) else $error("job pushed into a full queue");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty) else $error("job popped from an empty queue");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("queue fill count lost a push");

endmodule

`default_nettype wire

// File: sv/sld_back.sv
// sld_back: frame-end sequencer: two serial divides, squares, serial square root, scaling
// depends on sld_pkg and sld_rsp_if; one shared 17x17 multiplier, registered output
`default_nettype none

module sld_back import sld_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  geom_type geom,
   input  logic     queue_empty,
   input  job_type  head_job,
   output logic     pop,
   sld_rsp_if.source rsp_if
);

   localparam logic [4:0] DIV_LAST  = 5'd31;
   localparam logic [4:0] ROOT_LAST = 5'd15;
   localparam logic [30:0] ROOT_BIT_START = 31'h4000_0000;
   localparam logic signed [31:0] Q30_ONE = 32'sh4000_0000;

   typedef enum logic [3:0] {
      S_IDLE, S_DIV_X, S_SET_Y, S_DIV_Y, S_FIN_Y, S_SQ_X, S_SQ_Y, S_SUB,
      S_ROOT_SET, S_ROOT, S_ROUND, S_MUL_X, S_MUL_Y, S_MUL_Z, S_SEND
   } state_type;

   state_type               state_ff, state_in;
   job_type                 job_ff, job_in;
   logic [4:0]              cnt_ff, cnt_in;
   logic [31:0]             num_ff, num_in;
   logic [16:0]             rem_ff, rem_in;
   logic                    neg_ff, neg_in;
   logic signed [16:0]      nx_ff, nx_in;
   logic signed [16:0]      ny_ff, ny_in;
   logic                    flag_ff, flag_in;
   logic signed [33:0]      prod_ff;
   logic signed [31:0]      acc_ff, acc_in;
   logic [30:0]             v_ff, v_in;
   logic [31:0]             res_ff, res_in;
   logic [30:0]             bit_ff, bit_in;
   logic [15:0]             nz_ff, nz_in;
   logic signed [DIR_W-1:0] dir_x_ff, dir_x_in;
   logic signed [DIR_W-1:0] dir_y_ff, dir_y_in;
   logic                    rsp_valid_ff;
   logic signed [DIR_W-1:0] out_x_ff, out_y_ff;
   logic [DIR_Z_W-1:0]      out_z_ff;
   job_type                 out_job_ff;
   logic                    out_flag_ff;

   logic [RADIUS_W-1:0] radius_eff;
   logic [16:0]         den;
   logic [17:0]         rem_sh;
   logic                div_ge;
   logic [32:0]         root_sum;
   logic                root_ge;
   logic signed [16:0]  mul_a, mul_b;
   logic signed [33:0]  prod_in;
   logic signed [16:0]  lvl_s;
   logic                send;

   assign radius_eff = (geom.radius_q4 == '0) ? RADIUS_W'(1) : geom.radius_q4;
   assign den        = {radius_eff, 1'b0};
   assign rem_sh     = {rem_ff, num_ff[31]};
   assign div_ge     = rem_sh >= {1'b0, den};
   assign root_sum   = {1'b0, res_ff} + {2'b0, bit_ff};
   assign root_ge    = {2'b0, v_ff} >= root_sum;
   assign lvl_s      = $signed({9'b0, job_ff.level});
   assign prod_in    = mul_a * mul_b;
   assign send       = (state_ff == S_SEND) && (!rsp_valid_ff || rsp_if.ready);
   assign pop        = (state_ff == S_IDLE) && !queue_empty;

   // |coord - center| * 2^20 + r
   function automatic logic [32:0] div_setup(input logic [11:0] coord,
                                             input logic [11:0] center,
                                             input logic [RADIUS_W-1:0] r);
      logic [12:0] diff;
      logic [12:0] mag;
      diff = {1'b0, coord} - {1'b0, center};
      mag  = diff[12] ? (13'd0 - diff) : diff;
      div_setup = {diff[12], mag[11:0], 20'b0} + {17'b0, r};
   endfunction

   function automatic logic signed [16:0] unit_value(input logic [31:0] q, input logic neg);
      logic [16:0] mag;
      mag = (q > Q15_ONE) ? 17'd32768 : q[16:0];
      unit_value = neg ? $signed(17'd0 - mag) : $signed(mag);
   endfunction

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_SQ_X: begin
            mul_a = nx_ff;
            mul_b = nx_ff;
         end
         S_SQ_Y: begin
            mul_a = ny_ff;
            mul_b = ny_ff;
         end
         S_MUL_X: begin
            mul_a = nx_ff;
            mul_b = lvl_s;
         end
         S_MUL_Y: begin
            mul_a = ny_ff;
            mul_b = lvl_s;
         end
         // z product stays in prod_ff while the send step waits
         S_MUL_Z, S_SEND: begin
            mul_a = $signed({1'b0, nz_ff});
            mul_b = lvl_s;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      logic [32:0] setup;
      setup    = '0;
      state_in = state_ff;
      job_in   = job_ff;
      cnt_in   = cnt_ff;
      num_in   = num_ff;
      rem_in   = rem_ff;
      neg_in   = neg_ff;
      nx_in    = nx_ff;
      ny_in    = ny_ff;
      flag_in  = flag_ff;
      acc_in   = acc_ff;
      v_in     = v_ff;
      res_in   = res_ff;
      bit_in   = bit_ff;
      nz_in    = nz_ff;
      dir_x_in = dir_x_ff;
      dir_y_in = dir_y_ff;
      case (state_ff)
         S_IDLE: begin
            if (!queue_empty) begin
               setup    = div_setup(head_job.col, geom.center_col, radius_eff);
               job_in   = head_job;
               num_in   = setup[31:0];
               neg_in   = setup[32];
               rem_in   = '0;
               cnt_in   = '0;
               flag_in  = 1'b0;
               state_in = S_DIV_X;
            end
         end
         S_DIV_X, S_DIV_Y: begin
            rem_in = div_ge ? 17'(rem_sh - {1'b0, den}) : rem_sh[16:0];
            num_in = {num_ff[30:0], div_ge};
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == DIV_LAST) begin
               state_in = (state_ff == S_DIV_X) ? S_SET_Y : S_FIN_Y;
            end
         end
         S_SET_Y: begin
            nx_in    = unit_value(num_ff, neg_ff);
            flag_in  = flag_ff || (num_ff > Q15_ONE);
            setup    = div_setup(job_ff.row, geom.center_row, radius_eff);
            num_in   = setup[31:0];
            neg_in   = setup[32];
            rem_in   = '0;
            cnt_in   = '0;
            state_in = S_DIV_Y;
         end
         S_FIN_Y: begin
            ny_in    = unit_value(num_ff, neg_ff);
            flag_in  = flag_ff || (num_ff > Q15_ONE);
            state_in = S_SQ_X;
         end
         S_SQ_X: begin
            state_in = S_SQ_Y;
         end
         S_SQ_Y: begin
            acc_in   = Q30_ONE - $signed(prod_ff[31:0]);
            state_in = S_SUB;
         end
         S_SUB: begin
            acc_in   = acc_ff - $signed(prod_ff[31:0]);
            state_in = S_ROOT_SET;
         end
         S_ROOT_SET: begin
            if (acc_ff[31]) begin
               flag_in = 1'b1;
               v_in    = '0;
            end else begin
               v_in    = acc_ff[30:0];
            end
            res_in   = '0;
            bit_in   = ROOT_BIT_START;
            cnt_in   = '0;
            state_in = S_ROOT;
         end
         S_ROOT: begin
            if (root_ge) begin
               v_in   = 31'({2'b0, v_ff} - root_sum);
               res_in = (res_ff >> 1) + {1'b0, bit_ff};
            end else begin
               res_in = res_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == ROOT_LAST) begin
               state_in = S_ROUND;
            end
         end
         S_ROUND: begin
            nz_in    = 16'(res_ff + {31'b0, ({1'b0, v_ff} > res_ff)});
            state_in = S_MUL_X;
         end
         S_MUL_X: begin
            state_in = S_MUL_Y;
         end
         S_MUL_Y: begin
            dir_x_in = prod_ff[DIR_W-1:0];
            state_in = S_MUL_Z;
         end
         S_MUL_Z: begin
            dir_y_in = prod_ff[DIR_W-1:0];
            state_in = S_SEND;
         end
         S_SEND: begin
            if (send) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (send) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      job_ff   <= job_in;
      cnt_ff   <= cnt_in;
      num_ff   <= num_in;
      rem_ff   <= rem_in;
      neg_ff   <= neg_in;
      nx_ff    <= nx_in;
      ny_ff    <= ny_in;
      flag_ff  <= flag_in;
      prod_ff  <= prod_in;
      acc_ff   <= acc_in;
      v_ff     <= v_in;
      res_ff   <= res_in;
      bit_ff   <= bit_in;
      nz_ff    <= nz_in;
      dir_x_ff <= dir_x_in;
      dir_y_ff <= dir_y_in;
      if (send) begin
         out_x_ff    <= dir_x_ff;
         out_y_ff    <= dir_y_ff;
         out_z_ff    <= prod_ff[DIR_Z_W-1:0];
         out_job_ff  <= job_ff;
         out_flag_ff <= flag_ff;
      end
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.dir_x          = out_x_ff;
   assign rsp_if.dir_y          = out_y_ff;
   assign rsp_if.dir_z          = out_z_ff;
   assign rsp_if.best_col       = out_job_ff.col;
   assign rsp_if.best_row       = out_job_ff.row;
   assign rsp_if.peak_level     = out_job_ff.level;
   assign rsp_if.outside_sphere = out_flag_ff;

endmodule

`default_nettype wire

// File: sv/sphere_light_direction_core.sv
// sphere_light_direction_core: light direction from the highlight on a chrome sphere
// depends on sld_pkg, sld_req_if, sld_rsp_if, sld_front, sld_queue, sld_back
//
// usage:
//   req_if carries one gray pixel per request in raster order, last_pixel on the
//   final pixel of a frame. pixels are taken at one per cycle; ready drops only
//   while the job queue between front and back holds QUEUE_DEPTH frames.
//   rsp_if gives one result per frame: the sphere normal at the brightest pixel
//   (first one on a tie) scaled by its level, plus position, level and a flag.
//   from the last pixel to rsp valid the back sequencer runs two 32-step
//   serial divisions on one divider, a 16-step serial square root and five
//   passes through one shared 17x17 multiplier. the back works on one frame
//   at a time and pops the next job only when idle.
//   csr_we/csr_index/csr_wdata write center_col, center_row, radius_q4 and
//   image_width; write only while no frame is in flight.
//   reset is synchronous: counters, peak tracking, queue, back state and the
//   output valid clear, csr registers take their reset values. when the receiver
//   stalls the result holds in the output register and the back finishes the
//   next frame up to its send step.
`default_nettype none

module sphere_light_direction_core import sld_pkg::*; #(
   parameter int MAX_WIDTH   = MAX_WIDTH_DEFAULT,
   parameter int MAX_HEIGHT  = MAX_HEIGHT_DEFAULT,
   parameter int QUEUE_DEPTH = JOB_QUEUE_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   sld_req_if.sink                req_if,
   sld_rsp_if.source              rsp_if,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   geom_type           geom_ff;
   logic [WIDTH_W-1:0] image_width_ff;

   logic    push;
   job_type push_job;
   logic    pop;
   logic    queue_full;
   logic    queue_empty;
   job_type head_job;

   always_ff @(posedge clock) begin
      if (reset) begin
         geom_ff.center_col <= CENTER_COL_RESET;
         geom_ff.center_row <= CENTER_ROW_RESET;
         geom_ff.radius_q4  <= RADIUS_RESET;
         image_width_ff     <= IMAGE_WIDTH_RESET;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_CENTER_COL:  geom_ff.center_col <= csr_wdata[COL_W-1:0];
            CSR_CENTER_ROW:  geom_ff.center_row <= csr_wdata[ROW_W-1:0];
            CSR_RADIUS:      geom_ff.radius_q4  <= csr_wdata[RADIUS_W-1:0];
            CSR_IMAGE_WIDTH: image_width_ff     <= csr_wdata[WIDTH_W-1:0];
            default: begin
            end
         endcase
      end
   end

   sld_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .image_width (image_width_ff),
      .queue_full  (queue_full),
      .push        (push),
      .push_job    (push_job)
   );

   sld_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .full     (queue_full),
      .empty    (queue_empty),
      .head_job (head_job)
   );

   sld_back u_back (
      .clock       (clock),
      .reset       (reset),
      .geom        (geom_ff),
      .queue_empty (queue_empty),
      .head_job    (head_job),
      .pop         (pop),
      .rsp_if      (rsp_if)
   );

endmodule

`default_nettype wire
